[design/aavr_pkg.sv]
// Package for the axis-angle vector rotation block.
// Holds the pipeline constants, the sine polynomial coefficients and the
// fixed-point helper functions. Depends on nothing.
package aavr_pkg;

  localparam int ANGLE_BITS_DEF = 16;
  localparam int PHASE_BITS = 24;
  localparam int PIPE_LAT = 10;

  localparam logic [30:0] Q30_ONE = 31'd1073741824;
  localparam logic [30:0] C1 = 31'd1686629713;
  localparam logic [30:0] C3 = 31'd693598668;
  localparam logic [30:0] C5 = 31'd85569306;
  localparam logic [30:0] C7 = 31'd5026995;
  localparam logic [30:0] C9 = 31'd172272;

  typedef logic signed [17:0] q1_16_t;
  typedef logic signed [31:0] q16_16_t;

  // One step of the polynomial: c - ((w * t) >> 30).
  function automatic logic [30:0] horner(input logic [30:0] w, input logic [30:0] t,
                                         input logic [30:0] c);
    logic [61:0] p;
    p = {31'd0, w} * {31'd0, t};
    return c - p[60:30];
  endfunction

  // Rounds a Q30 magnitude to Q1.16 and applies the sign.
  function automatic q1_16_t to_q16(input logic [30:0] m, input logic neg);
    logic [30:0] s;
    q1_16_t r;
    s = m + 31'd8192;
    r = {1'b0, s[30:14]};
    return neg ? -r : r;
  endfunction

endpackage

[design/aavr_sincos.sv]
// Pipelined sine and cosine of a turn fraction, seven register stages.
// Evaluates the quarter-wave polynomial at u and 1-u and folds by quadrant.
// Depends on aavr_pkg.
module aavr_sincos #(
  parameter int ANGLE_BITS = aavr_pkg::ANGLE_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [15:0]          turn_fraction,
  output aavr_pkg::q1_16_t     sin_q,
  output aavr_pkg::q1_16_t     cos_q
);
  import aavr_pkg::*;

  localparam int SHAMT = PHASE_BITS - ANGLE_BITS;

  logic [23:0] phase;
  logic [23:0] phase_m;
  logic [30:0] u_in [2];

  logic [30:0] u_p [6][2];
  logic [30:0] w_p [4][2];
  logic [30:0] t_p [5][2];
  logic [1:0]  q_p [6];
  logic [30:0] s_clamp [2];

  assign phase   = {turn_fraction, 8'd0};
  assign phase_m = (phase >> SHAMT) << SHAMT;
  assign u_in[0] = {1'b0, phase_m[21:0], 8'd0};
  assign u_in[1] = Q30_ONE - u_in[0];

  always_comb begin
    logic [61:0] p;
    for (int k = 0; k < 2; k++) begin
      p = {31'd0, u_p[5][k]} * {31'd0, t_p[4][k]};
      s_clamp[k] = (p[61:30] > {1'b0, Q30_ONE}) ? Q30_ONE : p[60:30];
    end
  end

  always_ff @(posedge clk) begin
    logic [61:0] sq;
    if (en) begin
      for (int k = 0; k < 2; k++) begin
        sq = {31'd0, u_in[k]} * {31'd0, u_in[k]};
        u_p[0][k] <= u_in[k];
        w_p[0][k] <= sq[60:30];
        t_p[0][k] <= horner(w_p[0][k], C9, C7);
        t_p[1][k] <= horner(w_p[1][k], t_p[0][k], C5);
        t_p[2][k] <= horner(w_p[2][k], t_p[1][k], C3);
        t_p[3][k] <= horner(w_p[3][k], t_p[2][k], C1);
        for (int j = 1; j < 6; j++) begin
          u_p[j][k] <= u_p[j-1][k];
        end
        for (int j = 1; j < 4; j++) begin
          w_p[j][k] <= w_p[j-1][k];
        end
        t_p[4][k] <= t_p[3][k];
      end
      q_p[0] <= phase_m[23:22];
      for (int j = 1; j < 6; j++) begin
        q_p[j] <= q_p[j-1];
      end
      case (q_p[5])
        2'd0: begin
          sin_q <= to_q16(s_clamp[0], 1'b0);
          cos_q <= to_q16(s_clamp[1], 1'b0);
        end
        2'd1: begin
          sin_q <= to_q16(s_clamp[1], 1'b0);
          cos_q <= to_q16(s_clamp[0], 1'b1);
        end
        2'd2: begin
          sin_q <= to_q16(s_clamp[0], 1'b1);
          cos_q <= to_q16(s_clamp[1], 1'b1);
        end
        default: begin
          sin_q <= to_q16(s_clamp[1], 1'b1);
          cos_q <= to_q16(s_clamp[0], 1'b0);
        end
      endcase
    end
  end

endmodule

[design/aavr_rotate.sv]
// Vector datapath of the rotation: dot and cross products, scaling by sine
// and cosine, rounding and saturation, ten register stages.
// Depends on aavr_pkg; takes sine and cosine from aavr_sincos.
module aavr_rotate (
  input  logic                 clk,
  input  logic                 en,
  input  aavr_pkg::q1_16_t     axis_in [3],
  input  aavr_pkg::q16_16_t    point_in [3],
  input  aavr_pkg::q1_16_t     sin_q,
  input  aavr_pkg::q1_16_t     cos_q,
  output aavr_pkg::q16_16_t    rot [3],
  output logic                 sat
);
  import aavr_pkg::*;

  q1_16_t  nd [5][3];
  q16_16_t vd [5][3];

  logic signed [49:0] pdot [3];
  logic signed [49:0] pa [3];
  logic signed [49:0] pb [3];
  q1_16_t  n5 [3];
  q16_16_t v5 [3];

  logic signed [35:0] d16;
  logic signed [34:0] crh [3];
  q1_16_t  n6 [3];
  q16_16_t v6 [3];

  logic signed [54:0] m1;
  logic signed [49:0] per [3];
  logic signed [52:0] crs [3];
  q1_16_t  n7 [3];

  logic signed [56:0] par [3];
  logic signed [53:0] pc [3];

  logic signed [51:0] dot_c;
  logic signed [18:0] omc;
  logic signed [59:0] tot [3];
  logic signed [43:0] rr [3];
  logic [2:0] clip;

  assign dot_c = 52'(pdot[0]) + 52'(pdot[1]) + 52'(pdot[2]);
  assign omc = 19'sd65536 - 19'(cos_q);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      tot[i] = 60'(par[i]) + 60'(pc[i]) + 60'sd32768;
      rr[i] = 44'(tot[i] >>> 16);
      clip[i] = (rr[i] > 44'sd2147483647) || (rr[i] < -44'sd2147483648);
    end
  end

  always_ff @(posedge clk) begin
    logic signed [50:0] cr;
    logic signed [38:0] m1h;
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        nd[0][i] <= axis_in[i];
        vd[0][i] <= point_in[i];
        for (int j = 1; j < 5; j++) begin
          nd[j][i] <= nd[j-1][i];
          vd[j][i] <= vd[j-1][i];
        end
        pdot[i] <= nd[4][i] * vd[4][i];
        n5[i] <= nd[4][i];
        v5[i] <= vd[4][i];
        cr = 51'(pa[i]) - 51'(pb[i]);
        crh[i] <= 35'(cr >>> 16);
        n6[i] <= n5[i];
        v6[i] <= v5[i];
        per[i] <= v6[i] * cos_q;
        crs[i] <= crh[i] * sin_q;
        n7[i] <= n6[i];
        m1h = 39'(m1 >>> 16);
        par[i] <= n7[i] * m1h;
        pc[i] <= 54'(per[i]) + 54'(crs[i]);
        if (clip[i]) begin
          rot[i] <= rr[i][43] ? 32'sh80000000 : 32'sh7fffffff;
        end else begin
          rot[i] <= rr[i][31:0];
        end
      end
      pa[0] <= nd[4][1] * vd[4][2];
      pb[0] <= nd[4][2] * vd[4][1];
      pa[1] <= nd[4][2] * vd[4][0];
      pb[1] <= nd[4][0] * vd[4][2];
      pa[2] <= nd[4][0] * vd[4][1];
      pb[2] <= nd[4][1] * vd[4][0];
      d16 <= 36'(dot_c >>> 16);
      m1 <= d16 * omc;
      sat <= |clip;
    end
  end

endmodule

[design/axis_angle_vector_rotate.sv]
// Top level of the axis-angle vector rotation block (Rodrigues' formula).
// Instantiates aavr_sincos and aavr_rotate; uses aavr_pkg.
//
// Usage:
// Each input beat carries a turn fraction, an axis (Q1.16) and a point
// (Q16.16) and yields exactly one output beat with the rotated point and a
// flag that is set when any component was clipped to the 32-bit range.
// Both channels use valid and ready. The datapath is a ten-stage pipeline
// with one shared advance enable; it takes one beat every cycle while the
// output register is free or the receiver is ready.
// The last stage is the output register. When the receiver holds ready low
// while an output beat waits, the whole pipeline holds and in_ready falls;
// nothing is lost or repeated. The throughput of one beat per cycle is set
// by the pipelined multipliers of the sine polynomial and the vector path.
// Synchronous reset clears all valid bits; data registers are not reset.
module axis_angle_vector_rotate #(
  parameter int ANGLE_BITS = aavr_pkg::ANGLE_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [15:0]          turn_fraction,
  input  aavr_pkg::q1_16_t     axis_x,
  input  aavr_pkg::q1_16_t     axis_y,
  input  aavr_pkg::q1_16_t     axis_z,
  input  aavr_pkg::q16_16_t    point_x,
  input  aavr_pkg::q16_16_t    point_y,
  input  aavr_pkg::q16_16_t    point_z,
  output logic                 out_valid,
  input  logic                 out_ready,
  output aavr_pkg::q16_16_t    rotated_x,
  output aavr_pkg::q16_16_t    rotated_y,
  output aavr_pkg::q16_16_t    rotated_z,
  output logic                 saturated
);
  import aavr_pkg::*;

  logic [PIPE_LAT-1:0] vld;
  logic en;
  q1_16_t  sin_q;
  q1_16_t  cos_q;
  q1_16_t  axis_in [3];
  q16_16_t point_in [3];
  q16_16_t rot [3];

  assign en = !vld[PIPE_LAT-1] || out_ready;
  assign in_ready = en;
  assign out_valid = vld[PIPE_LAT-1];

  assign axis_in[0] = axis_x;
  assign axis_in[1] = axis_y;
  assign axis_in[2] = axis_z;
  assign point_in[0] = point_x;
  assign point_in[1] = point_y;
  assign point_in[2] = point_z;
  assign rotated_x = rot[0];
  assign rotated_y = rot[1];
  assign rotated_z = rot[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[PIPE_LAT-2:0], in_valid};
    end
  end

  aavr_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_sincos (
    .clk(clk),
    .en(en),
    .turn_fraction(turn_fraction),
    .sin_q(sin_q),
    .cos_q(cos_q)
  );

  aavr_rotate u_rotate (
    .clk(clk),
    .en(en),
    .axis_in(axis_in),
    .point_in(point_in),
    .sin_q(sin_q),
    .cos_q(cos_q),
    .rot(rot),
    .sat(saturated)
  );

endmodule

[design/aavr_checker.sv]
// Port-level checks for the axis-angle vector rotation block.
// Bound to axis_angle_vector_rotate; uses only its ports.
module aavr_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] rotated_x,
  input logic [31:0] rotated_y,
  input logic [31:0] rotated_z,
  input logic        saturated
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(rotated_x) && $stable(saturated))
    else $error("stalled output beat changed");

  a_sat_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |->
      rotated_x == 32'h7fffffff || rotated_x == 32'h80000000 ||
      rotated_y == 32'h7fffffff || rotated_y == 32'h80000000 ||
      rotated_z == 32'h7fffffff || rotated_z == 32'h80000000)
    else $error("saturation flag without a clipped component");

endmodule

bind axis_angle_vector_rotate aavr_checker u_aavr_checker (
  .clk(clk),
  .rst(rst),
  .in_ready(in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .rotated_x(rotated_x),
  .rotated_y(rotated_y),
  .rotated_z(rotated_z),
  .saturated(saturated)
);
